/* src/tcw_pkg.sv */
package tcw_pkg;

  // Default screen geometry.
  localparam int unsigned ColumnsDef = 80;
  localparam int unsigned RowsDef    = 25;

  // Fixed widths of the stream fields.
  localparam int unsigned CharW   = 8;
  localparam int unsigned IndexW  = 11;
  localparam int unsigned PosW    = 11;
  localparam int unsigned CellW   = 16;
  localparam int unsigned ColorW  = 8;
  localparam int unsigned OpW     = 2;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 32;

  // Character codes with a special meaning.
  localparam logic [CharW-1:0] ChNewline   = 8'h0A;
  localparam logic [CharW-1:0] ChBackspace = 8'h08;
  localparam logic [CharW-1:0] ChSpace     = 8'h20;

  // Register reset values.
  localparam logic [ColorW-1:0] TextColorRst  = 8'h0A;
  localparam logic [ColorW-1:0] BlankColorRst = 8'h07;

  // Operation carried by an input item.
  typedef enum logic [OpW-1:0] {
    OP_PRINT = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_TEXT_COLOR  = 1'b0,
    REG_BLANK_COLOR = 1'b1
  } cfg_reg_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_READ,
    S_GLYPH,
    S_SCROLL_COPY,
    S_SCROLL_BLANK,
    S_CLEAR,
    S_DONE,
    S_RESP
  } state_e;

endpackage

/* src/tcw_lin_addr.sv */
module tcw_lin_addr #(
  parameter int unsigned COLUMNS = tcw_pkg::ColumnsDef,
  parameter int unsigned ROWS    = tcw_pkg::RowsDef,
  localparam int unsigned RW = $clog2(ROWS),
  localparam int unsigned CW = $clog2(COLUMNS + 1),
  localparam int unsigned PW = $clog2(ROWS * COLUMNS + 1)
) (
  input  logic [RW-1:0] row_i,
  input  logic [CW-1:0] col_i,
  output logic [PW-1:0] lin_o
);

  // Linear cell position: row times the row length plus the column.
  assign lin_o = PW'(row_i) * PW'(COLUMNS) + PW'(col_i);

endmodule

/* src/text_console_writer_unit.sv */
// Steps from accept: glyph print S_EXEC, S_GLYPH, S_DONE; in-range read S_EXEC, S_READ,
// S_DONE; newline, backspace, out-of-range read and the unused op S_EXEC, S_DONE; clear
// sweeps every cell in S_CLEAR. A print that scrolls first copies the rows up one cell
// per cycle, then blanks the bottom row. Throughput: one item in work; the next is
// accepted the cycle after the result is taken. Reset: cursor to 0, colors to 10 and 7,
// then every cell (2000 by default) is blanked; no item is accepted, config writes are.
module text_console_writer_unit #(
  parameter int unsigned COLUMNS = tcw_pkg::ColumnsDef,
  parameter int unsigned ROWS    = tcw_pkg::RowsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input items.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: char_code [7:0], cell_index [18:8], zero fill [23:19].
  input  logic [tcw_pkg::InDataW-1:0]   s_axis_tdata,
  // tuser: op [1:0].
  input  logic [tcw_pkg::OpW-1:0]       s_axis_tuser,
  // Result items.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata: cursor_pos [10:0], cell_value [26:11], scrolled [27], zero fill [31:28].
  output logic [tcw_pkg::OutDataW-1:0]  m_axis_tdata,
  // Configuration writes.
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [tcw_pkg::ColorW-1:0]    cfg_data_i
);

  localparam int unsigned CELLS = ROWS * COLUMNS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned CW    = $clog2(COLUMNS + 1);
  localparam int unsigned PW    = $clog2(CELLS + 1);

  localparam logic [RW-1:0] RowLast  = RW'(ROWS - 1);
  localparam logic [CW-1:0] ColWrap  = CW'(COLUMNS);
  localparam logic [AW-1:0] CellLast = AW'(CELLS - 1);
  localparam logic [AW-1:0] CopyEnd  = AW'(CELLS - COLUMNS);

  tcw_pkg::state_e state_q, state_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic [AW-1:0] sweep_q, sweep_d;
  logic          scrolled_q, scrolled_d;
  logic          glyph_q, glyph_d;
  logic [tcw_pkg::CellW-1:0] cell_q, cell_d;
  logic [tcw_pkg::PosW-1:0]  pos_q, pos_d;
  logic          cp_wr_valid_q, cp_wr_valid_d;
  logic [AW-1:0] cp_wr_addr_q, cp_wr_addr_d;

  // Latched input item.
  tcw_pkg::op_e               op_q;
  logic [tcw_pkg::CharW-1:0]  ch_q;
  logic [tcw_pkg::IndexW-1:0] idx_q;

  // Configuration registers.
  logic [tcw_pkg::ColorW-1:0] text_color_q;
  logic [tcw_pkg::ColorW-1:0] blank_color_q;

  // Screen memory ports.
  logic [tcw_pkg::CellW-1:0] mem [CELLS];
  logic                      we;
  logic [AW-1:0]             waddr;
  logic [tcw_pkg::CellW-1:0] wdata;
  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  logic [tcw_pkg::CellW-1:0] rdata_q;

  // Shared address unit.
  logic [CW-1:0] unit_col;
  logic [PW-1:0] unit_lin;
  logic [31:0]   unit_lin32;
  logic [31:0]   idx32;
  logic          accept;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == tcw_pkg::S_IDLE);
  assign m_axis_tvalid = (state_q == tcw_pkg::S_RESP);
  assign m_axis_tdata  = {4'b0000, scrolled_q, cell_q, pos_q};

  // Backspace addresses the cell left of the cursor; all others the cursor cell.
  assign unit_col   = (state_q == tcw_pkg::S_EXEC) ? col_q - CW'(1) : col_q;
  assign unit_lin32 = 32'(unit_lin);
  assign idx32      = 32'(idx_q);

  tcw_lin_addr #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_lin_addr (
    .row_i (row_q),
    .col_i (unit_col),
    .lin_o (unit_lin)
  );

  // Screen memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Input item capture.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= tcw_pkg::op_e'(s_axis_tuser);
      ch_q  <= s_axis_tdata[7:0];
      idx_q <= s_axis_tdata[18:8];
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_color_q  <= tcw_pkg::TextColorRst;
      blank_color_q <= tcw_pkg::BlankColorRst;
    end else if (cfg_we_i) begin
      unique case (tcw_pkg::cfg_reg_e'(cfg_idx_i))
        tcw_pkg::REG_TEXT_COLOR:  text_color_q  <= cfg_data_i;
        tcw_pkg::REG_BLANK_COLOR: blank_color_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer and cursor registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= tcw_pkg::S_INIT;
      row_q         <= '0;
      col_q         <= '0;
      sweep_q       <= '0;
      scrolled_q    <= 1'b0;
      glyph_q       <= 1'b0;
      cp_wr_valid_q <= 1'b0;
    end else begin
      state_q       <= state_d;
      row_q         <= row_d;
      col_q         <= col_d;
      sweep_q       <= sweep_d;
      scrolled_q    <= scrolled_d;
      glyph_q       <= glyph_d;
      cp_wr_valid_q <= cp_wr_valid_d;
    end
  end

  // Result and copy payload registers.
  always_ff @(posedge clk_i) begin
    cell_q       <= cell_d;
    pos_q        <= pos_d;
    cp_wr_addr_q <= cp_wr_addr_d;
  end

  // Next state, memory access and result assembly.
  always_comb begin
    state_d       = state_q;
    row_d         = row_q;
    col_d         = col_q;
    sweep_d       = sweep_q;
    scrolled_d    = scrolled_q;
    glyph_d       = glyph_q;
    cell_d        = cell_q;
    pos_d         = pos_q;
    cp_wr_valid_d = 1'b0;
    cp_wr_addr_d  = cp_wr_addr_q;
    rd_en         = 1'b0;
    rd_addr       = idx32[AW-1:0];
    // A pending row copy owns the write port.
    we            = cp_wr_valid_q;
    waddr         = cp_wr_addr_q;
    wdata         = rdata_q;

    unique case (state_q)
      tcw_pkg::S_INIT: begin
        we    = 1'b1;
        waddr = sweep_q;
        wdata = {tcw_pkg::BlankColorRst, tcw_pkg::ChSpace};
        if (sweep_q == CellLast) begin
          sweep_d = '0;
          state_d = tcw_pkg::S_IDLE;
        end else begin
          sweep_d = sweep_q + AW'(1);
        end
      end

      tcw_pkg::S_IDLE: begin
        if (accept) begin
          state_d = tcw_pkg::S_EXEC;
        end
      end

      tcw_pkg::S_EXEC: begin
        scrolled_d = 1'b0;
        glyph_d    = 1'b0;
        cell_d     = '0;
        sweep_d    = '0;
        state_d    = tcw_pkg::S_DONE;
        unique case (op_q)
          tcw_pkg::OP_PRINT: begin
            priority if (ch_q == tcw_pkg::ChNewline) begin
              col_d = '0;
              if (row_q == RowLast) begin
                scrolled_d = 1'b1;
                state_d    = tcw_pkg::S_SCROLL_COPY;
              end else begin
                row_d = row_q + RW'(1);
              end
            end else if (ch_q == tcw_pkg::ChBackspace) begin
              if (col_q != '0) begin
                col_d = col_q - CW'(1);
                we    = 1'b1;
                waddr = unit_lin32[AW-1:0];
                wdata = {blank_color_q, tcw_pkg::ChSpace};
              end
            end else begin
              glyph_d = 1'b1;
              state_d = tcw_pkg::S_GLYPH;
              // Lazy wrap to the next row, scrolling past the last one.
              if (col_q == ColWrap) begin
                col_d = '0;
                if (row_q == RowLast) begin
                  scrolled_d = 1'b1;
                  state_d    = tcw_pkg::S_SCROLL_COPY;
                end else begin
                  row_d = row_q + RW'(1);
                end
              end
            end
          end
          tcw_pkg::OP_CLEAR: begin
            row_d   = '0;
            col_d   = '0;
            state_d = tcw_pkg::S_CLEAR;
          end
          tcw_pkg::OP_READ: begin
            if (idx32 < 32'(CELLS)) begin
              rd_en   = 1'b1;
              state_d = tcw_pkg::S_READ;
            end
          end
          default: ;
        endcase
      end

      tcw_pkg::S_READ: begin
        cell_d  = rdata_q;
        state_d = tcw_pkg::S_DONE;
      end

      tcw_pkg::S_GLYPH: begin
        we      = 1'b1;
        waddr   = unit_lin32[AW-1:0];
        wdata   = {text_color_q, ch_q};
        col_d   = col_q + CW'(1);
        state_d = tcw_pkg::S_DONE;
      end

      // Move every row up by one: read a cell a row below, write it in the next cycle.
      tcw_pkg::S_SCROLL_COPY: begin
        if (sweep_q != CopyEnd) begin
          rd_en         = 1'b1;
          rd_addr       = sweep_q + AW'(COLUMNS);
          cp_wr_valid_d = 1'b1;
          cp_wr_addr_d  = sweep_q;
          sweep_d       = sweep_q + AW'(1);
        end else begin
          state_d = tcw_pkg::S_SCROLL_BLANK;
        end
      end

      // Blank the bottom row.
      tcw_pkg::S_SCROLL_BLANK: begin
        we    = 1'b1;
        waddr = sweep_q;
        wdata = {blank_color_q, tcw_pkg::ChSpace};
        if (sweep_q == CellLast) begin
          sweep_d = '0;
          state_d = glyph_q ? tcw_pkg::S_GLYPH : tcw_pkg::S_DONE;
        end else begin
          sweep_d = sweep_q + AW'(1);
        end
      end

      tcw_pkg::S_CLEAR: begin
        we    = 1'b1;
        waddr = sweep_q;
        wdata = {blank_color_q, tcw_pkg::ChSpace};
        if (sweep_q == CellLast) begin
          sweep_d = '0;
          state_d = tcw_pkg::S_DONE;
        end else begin
          sweep_d = sweep_q + AW'(1);
        end
      end

      tcw_pkg::S_DONE: begin
        pos_d   = unit_lin32[tcw_pkg::PosW-1:0];
        state_d = tcw_pkg::S_RESP;
      end

      tcw_pkg::S_RESP: begin
        if (m_axis_tready) begin
          state_d = tcw_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = tcw_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* bench/text_console_writer_unit_tb.sv */
`timescale 1ns / 100ps

module text_console_writer_unit_tb;

  // Screen geometry as built into the block under test.
  localparam int unsigned Cols  = tcw_pkg::ColumnsDef;
  localparam int unsigned Rows  = tcw_pkg::RowsDef;
  localparam int unsigned Cells = Cols * Rows;

  // The operation code that the block must treat as a no-op.
  localparam logic [tcw_pkg::OpW-1:0] OpUnused = 2'd3;

  localparam int unsigned IdlePct      = 26;
  localparam int unsigned ItemsPerRun  = 110;
  localparam int unsigned NumRuns      = 5;
  localparam int unsigned CalmRun      = 2;
  localparam int unsigned DrainRun     = 3;
  localparam int unsigned HoldAtResult = 300;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned CycleLimit   = 10000000;
  localparam int unsigned MaxReports   = 10;

  // One result item of the console.
  typedef struct packed {
    logic [tcw_pkg::PosW-1:0]  pos;
    logic [tcw_pkg::CellW-1:0] cell_val;
    logic                      scrolled;
  } console_reply_t;

  // One row of the directed script; pinned rows carry a typed-in reply.
  typedef struct packed {
    logic [tcw_pkg::OpW-1:0]    op;
    logic [tcw_pkg::CharW-1:0]  ch;
    logic [tcw_pkg::IndexW-1:0] idx;
    logic [7:0]                 reps;
    logic                       pinned;
    console_reply_t             reply;
  } script_row_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [tcw_pkg::InDataW-1:0]    s_axis_tdata;
  logic [tcw_pkg::OpW-1:0]        s_axis_tuser;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [tcw_pkg::OutDataW-1:0]   m_axis_tdata;
  logic                           cfg_we_i;
  logic                           cfg_idx_i;
  logic [tcw_pkg::ColorW-1:0]     cfg_data_i;

  // Shadow copy of the console state.
  logic [tcw_pkg::CellW-1:0]  shadow_cells [Cells];
  int unsigned                cur_row;
  int unsigned                cur_col;
  logic [tcw_pkg::ColorW-1:0] text_attr;
  logic [tcw_pkg::ColorW-1:0] blank_attr;

  console_reply_t reply_queue [$];
  int unsigned    fail_count   = 0;
  int unsigned    results_seen = 0;
  int unsigned    cycle_count  = 0;
  int unsigned    hold_left    = 0;
  bit             hold_done    = 1'b0;
  bit             calm_phase   = 1'b0;
  int unsigned    line_left    = 0;

  // Directed script, run with the reset colors (text 0x0A, blank 0x07).
  script_row_t script_rows [25] = '{
    // Blank screen after reset, both ends, reads past the last cell and the unused op.
    '{tcw_pkg::OP_READ,  8'h00, 11'd0,    8'd1,  1'b1, '{11'd0,   16'h0720, 1'b0}},
    '{tcw_pkg::OP_READ,  8'h00, 11'd1999, 8'd1,  1'b1, '{11'd0,   16'h0720, 1'b0}},
    '{tcw_pkg::OP_READ,  8'h00, 11'd2000, 8'd1,  1'b1, '{11'd0,   16'h0000, 1'b0}},
    '{tcw_pkg::OP_READ,  8'h00, 11'h7FF,  8'd1,  1'b1, '{11'd0,   16'h0000, 1'b0}},
    '{OpUnused,          8'hFF, 11'h7FF,  8'd1,  1'b1, '{11'd0,   16'h0000, 1'b0}},
    // Top and bottom glyph bytes stay out of the color byte.
    '{tcw_pkg::OP_PRINT, 8'hFF, 11'd0,    8'd1,  1'b1, '{11'd1,   16'h0000, 1'b0}},
    '{tcw_pkg::OP_PRINT, 8'h00, 11'd0,    8'd1,  1'b1, '{11'd2,   16'h0000, 1'b0}},
    '{tcw_pkg::OP_READ,  8'h00, 11'd0,    8'd1,  1'b1, '{11'd2,   16'h0AFF, 1'b0}},
    '{tcw_pkg::OP_READ,  8'h00, 11'd1,    8'd1,  1'b1, '{11'd2,   16'h0A00, 1'b0}},
    // Backspace erases to the left; at column zero it does nothing.
    '{tcw_pkg::OP_PRINT, tcw_pkg::ChBackspace, 11'd0, 8'd1, 1'b1,
      '{11'd1, 16'h0000, 1'b0}},
    '{tcw_pkg::OP_READ,  8'h00, 11'd1,    8'd1,  1'b1, '{11'd1,   16'h0720, 1'b0}},
    '{tcw_pkg::OP_PRINT, tcw_pkg::ChNewline, 11'd0, 8'd1, 1'b1,
      '{11'd80, 16'h0000, 1'b0}},
    '{tcw_pkg::OP_PRINT, tcw_pkg::ChBackspace, 11'd0, 8'd1, 1'b1,
      '{11'd80, 16'h0000, 1'b0}},
    // Fill a row so the cursor rests past its end, then erase back.
    '{tcw_pkg::OP_PRINT, 8'h41, 11'd0,    8'd80, 1'b0, '0},
    '{tcw_pkg::OP_PRINT, tcw_pkg::ChBackspace, 11'd0, 8'd1, 1'b1,
      '{11'd159, 16'h0000, 1'b0}},
    '{tcw_pkg::OP_READ,  8'h00, 11'd159,  8'd1,  1'b1, '{11'd159, 16'h0720, 1'b0}},
    '{tcw_pkg::OP_PRINT, 8'h42, 11'd0,    8'd1,  1'b0, '0},
    '{tcw_pkg::OP_PRINT, 8'h43, 11'd0,    8'd1,  1'b0, '0},
    // Newlines down past the last row, then a glyph that wraps and scrolls.
    '{tcw_pkg::OP_PRINT, tcw_pkg::ChNewline, 11'd0, 8'd23, 1'b0, '0},
    '{tcw_pkg::OP_READ,  8'h00, 11'd80,   8'd1,  1'b0, '0},
    '{tcw_pkg::OP_PRINT, 8'h5A, 11'd0,    8'd81, 1'b0, '0},
    // Clear, then read back blanks, also at alternating address bits.
    '{tcw_pkg::OP_CLEAR, 8'h00, 11'd0,    8'd1,  1'b1, '{11'd0,   16'h0000, 1'b0}},
    '{tcw_pkg::OP_READ,  8'h00, 11'd1919, 8'd1,  1'b1, '{11'd0,   16'h0720, 1'b0}},
    '{tcw_pkg::OP_READ,  8'h00, 11'h555,  8'd1,  1'b1, '{11'd0,   16'h0720, 1'b0}},
    '{tcw_pkg::OP_READ,  8'h00, 11'h2AA,  8'd1,  1'b1, '{11'd0,   16'h0720, 1'b0}}
  };

  text_console_writer_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Fill the whole shadow screen with blanks in the current blank color.
  function automatic void blank_screen();
    for (int i = 0; i < Cells; i++) begin
      shadow_cells[i] = {blank_attr, tcw_pkg::ChSpace};
    end
  endfunction

  // Move every row up by one and blank the bottom row.
  function automatic void shift_screen_up();
    for (int i = 0; i < Cells - Cols; i++) begin
      shadow_cells[i] = shadow_cells[i + Cols];
    end
    for (int i = Cells - Cols; i < Cells; i++) begin
      shadow_cells[i] = {blank_attr, tcw_pkg::ChSpace};
    end
    cur_row = Rows - 1;
  endfunction

  // Apply one item to the shadow console and return the reply it must give.
  function automatic console_reply_t console_apply(
      input logic [tcw_pkg::OpW-1:0] op,
      input logic [tcw_pkg::CharW-1:0] ch,
      input logic [tcw_pkg::IndexW-1:0] idx);
    console_reply_t r;
    r = '0;
    case (op)
      tcw_pkg::OP_PRINT: begin
        if (ch == tcw_pkg::ChNewline) begin
          cur_col = 0;
          cur_row++;
          if (cur_row >= Rows) begin
            shift_screen_up();
            r.scrolled = 1'b1;
          end
        end else if (ch == tcw_pkg::ChBackspace) begin
          if (cur_col > 0) begin
            cur_col--;
            shadow_cells[cur_row * Cols + cur_col] = {blank_attr, tcw_pkg::ChSpace};
          end
        end else begin
          // A glyph after a full row first wraps to the next one.
          if (cur_col >= Cols) begin
            cur_col = 0;
            cur_row++;
          end
          if (cur_row >= Rows) begin
            shift_screen_up();
            r.scrolled = 1'b1;
          end
          shadow_cells[cur_row * Cols + cur_col] = {text_attr, ch};
          cur_col++;
        end
      end
      tcw_pkg::OP_CLEAR: begin
        blank_screen();
        cur_row = 0;
        cur_col = 0;
      end
      tcw_pkg::OP_READ: begin
        if (idx < Cells) begin
          r.cell_val = shadow_cells[idx];
        end
      end
      default: begin
      end
    endcase
    r.pos = tcw_pkg::PosW'(cur_row * Cols + cur_col);
    return r;
  endfunction

  // Offer one item, wait for the handshake and record the reply it must give.
  task automatic send_item(input logic [tcw_pkg::OpW-1:0] op,
                           input logic [tcw_pkg::CharW-1:0] ch,
                           input logic [tcw_pkg::IndexW-1:0] idx, input logic pinned,
                           input console_reply_t pinned_reply);
    console_reply_t want;
    while (!calm_phase && $urandom_range(0, 99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, idx, ch};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    want = console_apply(op, ch, idx);
    reply_queue.push_back(pinned ? pinned_reply : want);
  endtask

  // Mostly lines of glyphs ended by a newline, mixed with edits, reads and noise.
  task automatic pick_random_item(output logic [tcw_pkg::OpW-1:0] op,
                                  output logic [tcw_pkg::CharW-1:0] ch,
                                  output logic [tcw_pkg::IndexW-1:0] idx);
    int unsigned roll;
    int unsigned here;
    roll = $urandom_range(0, 99);
    here = cur_row * Cols + cur_col;
    op   = tcw_pkg::OP_PRINT;
    ch   = tcw_pkg::CharW'($urandom_range(0, 255));
    idx  = tcw_pkg::IndexW'($urandom_range(0, 2047));
    if (line_left > 0) begin
      line_left--;
      if (roll < 8) begin
        op  = tcw_pkg::OP_READ;
        idx = tcw_pkg::IndexW'((here > 0) ? here - 1 : 0);
      end else if (roll < 12) begin
        ch = tcw_pkg::ChBackspace;
      end
    end else if (roll < 40) begin
      ch = tcw_pkg::ChNewline;
      line_left = ($urandom_range(0, 99) < 20) ? $urandom_range(70, 100)
                                               : $urandom_range(0, 12);
    end else if (roll < 52) begin
      ch = tcw_pkg::ChBackspace;
    end else if (roll < 64) begin
      op  = tcw_pkg::OP_READ;
      idx = tcw_pkg::IndexW'($urandom_range(0, Cells - 1));
    end else if (roll < 72) begin
      op  = tcw_pkg::OP_READ;
      idx = tcw_pkg::IndexW'((here > 40) ? here - $urandom_range(1, 40) : here);
    end else if (roll < 75) begin
      op  = tcw_pkg::OP_READ;
      idx = tcw_pkg::IndexW'($urandom_range(Cells, 2047));
    end else if (roll < 77) begin
      op = tcw_pkg::OP_CLEAR;
    end else if (roll < 80) begin
      op = OpUnused;
    end
  endtask

  // Write both color registers; only called while the console is idle.
  task automatic set_colors(input logic [tcw_pkg::ColorW-1:0] text_val,
                            input logic [tcw_pkg::ColorW-1:0] blank_val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= tcw_pkg::REG_TEXT_COLOR;
    cfg_data_i <= text_val;
    @(posedge clk_i);
    text_attr = text_val;
    cfg_idx_i  <= tcw_pkg::REG_BLANK_COLOR;
    cfg_data_i <= blank_val;
    @(posedge clk_i);
    blank_attr = blank_val;
    cfg_we_i <= 1'b0;
  endtask

  // Result side: compare each result with the oldest expectation, drive tready.
  always @(posedge clk_i) begin : result_check
    console_reply_t want;
    console_reply_t got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata[10:0], m_axis_tdata[26:11], m_axis_tdata[27]};
        results_seen++;
        if (reply_queue.size() == 0) begin
          if (fail_count < MaxReports) begin
            $display("result %0d with nothing expected: pos %0d cell %h scrolled %0d",
                     results_seen, got.pos, got.cell_val, got.scrolled);
          end
          fail_count++;
        end else begin
          want = reply_queue.pop_front();
          if (got !== want) begin
            if (fail_count < MaxReports) begin
              $display("result %0d: expected pos %0d cell %h scrolled %0d,",
                       results_seen, want.pos, want.cell_val, want.scrolled,
                       " got pos %0d cell %h scrolled %0d",
                       got.pos, got.cell_val, got.scrolled);
            end
            fail_count++;
          end
        end
      end
      // One long hold-off lets the input side back up against a full block.
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (results_seen == HoldAtResult && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm_phase || ($urandom_range(0, 99) >= IdlePct);
      end
    end else begin
      m_axis_tready <= 1'b0;
    end
  end

  // Guard against a hang.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("text_console_writer_unit_tb: done, errors");
      $finish;
    end
  end

  // Stimulus: reset, directed script, then randomized runs under several color settings.
  initial begin
    logic [tcw_pkg::OpW-1:0]    op;
    logic [tcw_pkg::CharW-1:0]  ch;
    logic [tcw_pkg::IndexW-1:0] idx;
    logic [tcw_pkg::ColorW-1:0] text_val;
    logic [tcw_pkg::ColorW-1:0] blank_val;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= tcw_pkg::REG_TEXT_COLOR;
    cfg_data_i    <= '0;
    text_attr  = tcw_pkg::TextColorRst;
    blank_attr = tcw_pkg::BlankColorRst;
    cur_row    = 0;
    cur_col    = 0;
    blank_screen();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (script_rows[r]) begin
      for (int k = 0; k < script_rows[r].reps; k++) begin
        send_item(script_rows[r].op, script_rows[r].ch, script_rows[r].idx,
                  script_rows[r].pinned, script_rows[r].reply);
      end
    end

    for (int run = 0; run < NumRuns; run++) begin
      // Drain, let the block settle, then change colors.
      s_axis_tvalid <= 1'b0;
      while (reply_queue.size() != 0) @(posedge clk_i);
      repeat (8) @(posedge clk_i);
      case (run)
        0: begin
          text_val  = 8'hFF;
          blank_val = 8'h00;
        end
        1: begin
          text_val  = 8'h00;
          blank_val = 8'hFF;
        end
        default: begin
          text_val  = tcw_pkg::ColorW'($urandom_range(0, 255));
          blank_val = tcw_pkg::ColorW'($urandom_range(0, 255));
        end
      endcase
      set_colors(text_val, blank_val);
      calm_phase = (run == CalmRun);
      for (int n = 0; n < ItemsPerRun; n++) begin
        // Once, hold the input back until every result is in.
        if (run == DrainRun && n == ItemsPerRun / 2) begin
          s_axis_tvalid <= 1'b0;
          while (reply_queue.size() != 0) @(posedge clk_i);
        end
        pick_random_item(op, ch, idx);
        send_item(op, ch, idx, 1'b0, '0);
      end
      calm_phase = 1'b0;
    end

    s_axis_tvalid <= 1'b0;
    while (reply_queue.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0 && reply_queue.size() == 0) begin
      $display("text_console_writer_unit_tb: done, clean");
    end else begin
      $display("text_console_writer_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

/* text_console_writer_unit.f */
src/tcw_pkg.sv
src/tcw_lin_addr.sv
src/text_console_writer_unit.sv
bench/text_console_writer_unit_tb.sv
